// ===== hw/rtl/mis_pkg.sv =====
// Shared payload types for the merge-insertion sorter.
package mis_pkg;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic               last_res;
		logic               truncated;
	} res_t;

	typedef struct packed {
		logic less;
		logic go_low;
	} cmp_res_t;

endpackage

// ===== hw/rtl/mis_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module mis_ram #(
	parameter int DW    = 32,
	parameter int AW    = 6,
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/mis_cmp.sv =====
// Shared signed comparator with binary-search bound update.
module mis_cmp #(
	parameter int IW = 7
) (
	input  logic signed [31:0] op_a,
	input  logic signed [31:0] op_b,
	input  logic signed [IW:0] mid,
	output mis_pkg::cmp_res_t  res,
	output logic signed [IW:0] lo_nx,
	output logic signed [IW:0] hi_nx
);
	assign res.less   = op_a < op_b;
	assign res.go_low = op_a < op_b;
	assign lo_nx      = mid + (IW+1)'(1);
	assign hi_nx      = mid - (IW+1)'(1);
endmodule

// ===== hw/rtl/merge_insertion_sorter_top.sv =====
// Top level: block load, Ford-Johnson sort sequencer and result output.
//
// Usage: values arrive one beat per item on item_valid/item_ready; the beat
// with last set closes the block. Up to MAX_ITEMS values are held; extra
// values are dropped and every result of that block carries truncated.
// After the last beat the block sorts in place with one shared comparator
// and one port on each of three RAMs (values, copy, chain order). A pair
// compare reads both values, then compares them; a swap exchanges the
// values word by word; each binary-search probe reads the chain, then the
// value; each chain shift reads and writes one entry; every insertion level
// regroups the values through the copy RAM. Chain shifts dominate.
// Results then leave ascending, one beat per res_valid/res_ready handshake;
// a new result is read only after the last one is taken. last_res marks
// the final one. item_ready is high only while loading. A stalled receiver
// simply holds the result register; nothing is lost. Reset (arst_n low)
// empties the block and returns to loading. Value storage needs no clearing.
module merge_insertion_sorter_top #(
	parameter int MAX_ITEMS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  mis_pkg::item_t item,
	output logic           res_valid,
	input  logic           res_ready,
	output mis_pkg::res_t  res
);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int XW = CW + 2;
	localparam int LW = (CW > 1) ? $clog2(CW) : 1;
	localparam int JW = 14;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_PL_CHK  = 5'd1;
	localparam logic [4:0] S_PL_A    = 5'd2;
	localparam logic [4:0] S_PL_B    = 5'd3;
	localparam logic [4:0] S_PL_C    = 5'd4;
	localparam logic [4:0] S_SW_A    = 5'd5;
	localparam logic [4:0] S_SW_B    = 5'd6;
	localparam logic [4:0] S_SW_C    = 5'd7;
	localparam logic [4:0] S_SW_D    = 5'd8;
	localparam logic [4:0] S_LV_UP   = 5'd9;
	localparam logic [4:0] S_LV_DN   = 5'd10;
	localparam logic [4:0] S_CH_INIT = 5'd11;
	localparam logic [4:0] S_BATCH   = 5'd12;
	localparam logic [4:0] S_K_RD    = 5'd13;
	localparam logic [4:0] S_K_WT    = 5'd14;
	localparam logic [4:0] S_BS_CHK  = 5'd15;
	localparam logic [4:0] S_BS_C    = 5'd16;
	localparam logic [4:0] S_BS_V    = 5'd17;
	localparam logic [4:0] S_MV_CHK  = 5'd18;
	localparam logic [4:0] S_MV_W    = 5'd19;
	localparam logic [4:0] S_MV_END  = 5'd20;
	localparam logic [4:0] S_CP_R    = 5'd21;
	localparam logic [4:0] S_CP_W    = 5'd22;
	localparam logic [4:0] S_RW_C    = 5'd23;
	localparam logic [4:0] S_RW_S    = 5'd24;
	localparam logic [4:0] S_RW_R    = 5'd25;
	localparam logic [4:0] S_RW_W    = 5'd26;
	localparam logic [4:0] S_OUT_RD  = 5'd27;
	localparam logic [4:0] S_OUT_LD  = 5'd28;
	localparam logic [4:0] S_OUT_WT  = 5'd29;

	logic [4:0]           state_q;
	logic [CW-1:0]        cnt_q;
	logic                 ov_q;
	logic [CW-1:0]        es_q;
	logic [LW-1:0]        lg_q;
	logic [XW-1:0]        base_q;
	logic [CW-1:0]        k_q;
	logic [31:0]          t_q;
	logic [CW-1:0]        m_q;
	logic [CW-1:0]        pend_q;
	logic [CW-1:0]        fg_q;
	logic [JW-1:0]        jp_q;
	logic [JW-1:0]        jc_q;
	logic [CW-1:0]        rng_q;
	logic [CW-1:0]        bat_q;
	logic [CW-1:0]        i_q;
	logic [AW-1:0]        idx_q;
	logic [31:0]          key_q;
	logic signed [CW:0]   lo_q;
	logic signed [CW:0]   hi_q;
	logic signed [CW:0]   mid_q;
	logic [CW-1:0]        slot_q;
	logic [CW-1:0]        j_q;
	logic [CW-1:0]        c_q;
	logic [CW-1:0]        r_q;
	logic [AW-1:0]        start_q;
	mis_pkg::res_t        res_q;
	logic                 rvld_q;

	logic          val_we;
	logic [AW-1:0] val_wa;
	logic [31:0]   val_wd;
	logic [AW-1:0] val_ra;
	logic [31:0]   val_rd;
	logic          ch_we;
	logic [AW-1:0] ch_wa;
	logic [AW-1:0] ch_wd;
	logic [AW-1:0] ch_ra;
	logic [AW-1:0] ch_rd;
	logic          cp_we;
	logic [31:0]   cp_rd;

	logic                 acc;
	logic [XW-1:0]        n_x;
	logic [XW-1:0]        es_x;
	logic [XW-1:0]        ia_x;
	logic [XW-1:0]        ib_x;
	logic [CW-1:0]        groups;
	logic [CW-1:0]        mc;
	logic [XW-1:0]        idx_x;
	logic [XW-1:0]        chv_x;
	logic signed [CW:0]   mid_c;
	logic signed [31:0]   cmp_a;
	logic signed [31:0]   cmp_b;
	mis_pkg::cmp_res_t    cmp_r;
	logic signed [CW:0]   lo_nx;
	logic signed [CW:0]   hi_nx;
	logic [JW-1:0]        diff;
	logic [CW:0]          rng2;

	assign acc        = item_valid && item_ready;
	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = rvld_q;
	assign res        = res_q;

	assign n_x    = XW'(cnt_q);
	assign es_x   = XW'(es_q);
	assign ia_x   = base_q + es_x - XW'(1);
	assign ib_x   = ia_x + es_x;
	assign groups = cnt_q >> lg_q;
	assign mc     = CW'(1) + (groups >> 1);
	assign idx_x  = ((XW'(fg_q) + (XW'(i_q) << 1) + XW'(1)) << lg_q) - XW'(1);
	assign chv_x  = (j_q == '0) ? (es_x - XW'(1)) : (((XW'(j_q) << 1) << lg_q) - XW'(1));
	assign mid_c  = lo_q + ((hi_q - lo_q) >>> 1);
	assign diff   = jc_q - jp_q;
	assign rng2   = {rng_q, 1'b1};

	assign cmp_a = (state_q == S_PL_C) ? val_rd : key_q;
	assign cmp_b = (state_q == S_PL_C) ? t_q : val_rd;

	mis_cmp #(.IW(CW)) u_cmp (
		.op_a (cmp_a),
		.op_b (cmp_b),
		.mid  (mid_q),
		.res  (cmp_r),
		.lo_nx(lo_nx),
		.hi_nx(hi_nx)
	);

	always_comb begin
		val_we = 1'b0;
		val_wa = '0;
		val_wd = '0;
		val_ra = '0;
		ch_we  = 1'b0;
		ch_wa  = '0;
		ch_wd  = '0;
		ch_ra  = '0;
		cp_we  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				val_we = acc && (cnt_q != CW'(MAX_ITEMS));
				val_wa = cnt_q[AW-1:0];
				val_wd = item.value;
			end
			S_PL_A:   val_ra = ia_x[AW-1:0];
			S_PL_B:   val_ra = ib_x[AW-1:0];
			S_SW_A:   val_ra = ia_x[AW-1:0] - k_q[AW-1:0];
			S_SW_B:   val_ra = ib_x[AW-1:0] - k_q[AW-1:0];
			S_SW_C: begin
				val_we = 1'b1;
				val_wa = ia_x[AW-1:0] - k_q[AW-1:0];
				val_wd = val_rd;
			end
			S_SW_D: begin
				val_we = 1'b1;
				val_wa = ib_x[AW-1:0] - k_q[AW-1:0];
				val_wd = t_q;
			end
			S_CH_INIT: begin
				ch_we = 1'b1;
				ch_wa = j_q[AW-1:0];
				ch_wd = chv_x[AW-1:0];
			end
			S_K_RD:   val_ra = idx_x[AW-1:0];
			S_BS_CHK: ch_ra = mid_c[AW-1:0];
			S_BS_C:   val_ra = ch_rd;
			S_MV_CHK: ch_ra = j_q[AW-1:0] - AW'(1);
			S_MV_W: begin
				ch_we = 1'b1;
				ch_wa = j_q[AW-1:0];
				ch_wd = ch_rd;
			end
			S_MV_END: begin
				ch_we = 1'b1;
				ch_wa = slot_q[AW-1:0];
				ch_wd = idx_q;
			end
			S_CP_R:   val_ra = c_q[AW-1:0];
			S_CP_W:   cp_we = 1'b1;
			S_RW_C:   ch_ra = c_q[AW-1:0];
			S_RW_W: begin
				val_we = 1'b1;
				val_wa = r_q[AW-1:0];
				val_wd = cp_rd;
			end
			S_OUT_RD: val_ra = k_q[AW-1:0];
			default: begin
			end
		endcase
	end

	mis_ram #(.DW(32), .AW(AW), .DEPTH(MAX_ITEMS)) u_val (
		.clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
		.raddr(val_ra), .rdata(val_rd)
	);

	mis_ram #(.DW(32), .AW(AW), .DEPTH(MAX_ITEMS)) u_copy (
		.clk(clk), .we(cp_we), .waddr(c_q[AW-1:0]), .wdata(val_rd),
		.raddr(start_q + k_q[AW-1:0]), .rdata(cp_rd)
	);

	mis_ram #(.DW(AW), .AW(AW), .DEPTH(MAX_ITEMS)) u_chain (
		.clk(clk), .we(ch_we), .waddr(ch_wa), .wdata(ch_wd),
		.raddr(ch_ra), .rdata(ch_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			es_q    <= CW'(1);
			lg_q    <= '0;
			rvld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (cnt_q != CW'(MAX_ITEMS)) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ov_q <= 1'b1;
						end
						if (item.last) begin
							es_q    <= CW'(1);
							lg_q    <= '0;
							state_q <= S_PL_CHK;
						end
					end
				end
				S_PL_CHK: state_q <= (base_q + (es_x << 1) <= n_x) ? S_PL_A : S_LV_UP;
				S_PL_A:   state_q <= S_PL_B;
				S_PL_B:   state_q <= S_PL_C;
				S_PL_C: begin
					if (cmp_r.less) begin
						state_q <= S_SW_A;
					end else begin
						state_q <= S_PL_CHK;
					end
				end
				S_SW_A: state_q <= S_SW_B;
				S_SW_B: state_q <= S_SW_C;
				S_SW_C: state_q <= S_SW_D;
				S_SW_D: state_q <= (k_q == es_q - CW'(1)) ? S_PL_CHK : S_SW_A;
				S_LV_UP: begin
					es_q    <= es_q << 1;
					lg_q    <= lg_q + LW'(1);
					state_q <= (n_x >= (es_x << 2)) ? S_PL_CHK : S_LV_DN;
				end
				S_LV_DN: begin
					if (es_q == CW'(1)) begin
						state_q <= S_OUT_RD;
					end else begin
						es_q <= es_q >> 1;
						lg_q <= lg_q - LW'(1);
						if (cnt_q >= es_q) begin
							state_q <= S_CH_INIT;
						end
					end
				end
				S_CH_INIT: if (j_q == mc - CW'(1)) state_q <= S_BATCH;
				S_BATCH:   state_q <= (pend_q == '0) ? S_CP_R : S_K_RD;
				S_K_RD:    state_q <= S_K_WT;
				S_K_WT:    state_q <= S_BS_CHK;
				S_BS_CHK:  state_q <= (lo_q <= hi_q) ? S_BS_C : S_MV_CHK;
				S_BS_C:    state_q <= S_BS_V;
				S_BS_V:    state_q <= S_BS_CHK;
				S_MV_CHK:  state_q <= (j_q > slot_q) ? S_MV_W : S_MV_END;
				S_MV_W:    state_q <= S_MV_CHK;
				S_MV_END:  state_q <= (i_q == CW'(1)) ? S_BATCH : S_K_RD;
				S_CP_R:    state_q <= S_CP_W;
				S_CP_W:    state_q <= (c_q == cnt_q - CW'(1)) ? S_RW_C : S_CP_R;
				S_RW_C:    state_q <= S_RW_S;
				S_RW_S:    state_q <= S_RW_R;
				S_RW_R:    state_q <= S_RW_W;
				S_RW_W: begin
					if (k_q == es_q - CW'(1)) begin
						state_q <= (c_q == m_q - CW'(1)) ? S_LV_DN : S_RW_C;
					end else begin
						state_q <= S_RW_R;
					end
				end
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: begin
					rvld_q  <= 1'b1;
					state_q <= S_OUT_WT;
				end
				S_OUT_WT: begin
					if (res_ready) begin
						rvld_q <= 1'b0;
						if (k_q == cnt_q - CW'(1)) begin
							cnt_q   <= '0;
							ov_q    <= 1'b0;
							es_q    <= CW'(1);
							state_q <= S_IDLE;
						end else begin
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: base_q <= '0;
			S_PL_B: t_q <= val_rd;
			S_PL_C: begin
				k_q <= '0;
				if (!cmp_r.less) begin
					base_q <= base_q + (es_x << 1);
				end
			end
			S_SW_B: t_q <= val_rd;
			S_SW_D: begin
				if (k_q == es_q - CW'(1)) begin
					base_q <= base_q + (es_x << 1);
				end
				k_q <= k_q + CW'(1);
			end
			S_LV_UP: base_q <= '0;
			S_LV_DN: begin
				j_q <= '0;
				k_q <= '0;
			end
			S_CH_INIT: begin
				j_q <= j_q + CW'(1);
				if (j_q == mc - CW'(1)) begin
					m_q    <= mc;
					pend_q <= groups - mc;
					fg_q   <= '0;
					jp_q   <= JW'(1);
					jc_q   <= JW'(3);
					rng_q  <= CW'(1);
				end
			end
			S_BATCH: begin
				c_q <= '0;
				if (diff > JW'(pend_q)) begin
					bat_q <= pend_q;
					i_q   <= pend_q;
				end else begin
					bat_q <= diff[CW-1:0];
					i_q   <= diff[CW-1:0];
				end
				if (jc_q < JW'(4096)) begin
					jp_q <= jc_q;
					jc_q <= jc_q + (jp_q << 1);
				end
				if (rng2 > (CW+1)'(m_q)) begin
					rng_q <= m_q;
				end else begin
					rng_q <= rng2[CW-1:0];
				end
			end
			S_K_RD: idx_q <= idx_x[AW-1:0];
			S_K_WT: begin
				key_q  <= val_rd;
				lo_q   <= '0;
				hi_q   <= $signed({1'b0, rng_q}) - (CW+1)'(1);
				slot_q <= '0;
			end
			S_BS_CHK: begin
				mid_q <= mid_c;
				j_q   <= m_q;
			end
			S_BS_V: begin
				if (cmp_r.go_low) begin
					hi_q   <= hi_nx;
					slot_q <= mid_q[CW-1:0];
				end else begin
					lo_q   <= lo_nx;
					slot_q <= lo_nx[CW-1:0];
				end
			end
			S_MV_W: j_q <= j_q - CW'(1);
			S_MV_END: begin
				m_q <= m_q + CW'(1);
				i_q <= i_q - CW'(1);
				if (i_q == CW'(1)) begin
					fg_q   <= fg_q + (bat_q << 1);
					pend_q <= pend_q - bat_q;
				end
			end
			S_CP_W: begin
				if (c_q == cnt_q - CW'(1)) begin
					c_q <= '0;
					r_q <= '0;
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
			S_RW_S: begin
				start_q <= ch_rd + AW'(1) - es_q[AW-1:0];
				k_q     <= '0;
			end
			S_RW_W: begin
				r_q <= r_q + CW'(1);
				k_q <= k_q + CW'(1);
				if (k_q == es_q - CW'(1)) begin
					c_q <= c_q + CW'(1);
				end
			end
			S_OUT_LD: begin
				res_q.value_res <= val_rd;
				res_q.last_res  <= (k_q == cnt_q - CW'(1));
				res_q.truncated <= ov_q;
			end
			S_OUT_WT: if (res_ready) k_q <= k_q + CW'(1);
			default: begin
			end
		endcase
	end
endmodule
